// ===== rtl/core/hkvs_pkg.sv =====
// Shared types and constants of the hashed key-value store.
// Used by the controller, the datapath, the residue unit and the top level.
`default_nettype none

package hkvs_pkg;

   localparam int KEY_W  = 32;
   localparam int VAL_W  = 32;
   localparam int OP_W   = 2;
   localparam int STAT_W = 2;

   // key bits folded into the bucket residue per cycle
   localparam int MOD_BITS = 8;

   localparam logic [OP_W-1:0] OP_INSERT = 2'd0;
   localparam logic [OP_W-1:0] OP_LOOKUP = 2'd1;
   localparam logic [OP_W-1:0] OP_REMOVE = 2'd2;

   localparam logic [STAT_W-1:0] STAT_OK        = 2'd0;
   localparam logic [STAT_W-1:0] STAT_NOT_FOUND = 2'd1;
   localparam logic [STAT_W-1:0] STAT_FULL      = 2'd2;

   localparam logic signed [VAL_W-1:0] ABSENT_VALUE = -32'sd1;

   typedef struct packed {
      logic [OP_W-1:0]         opcode;
      logic signed [KEY_W-1:0] key;
      logic signed [VAL_W-1:0] new_value;
   } req_type;

   typedef struct packed {
      logic [STAT_W-1:0]       status;
      logic signed [VAL_W-1:0] read_value;
   } rsp_type;

   typedef enum logic [2:0] {
      S_CLEAR,
      S_IDLE,
      S_HASH,
      S_EXEC,
      S_POST
   } ctrl_state_type;

   // controller to datapath
   typedef struct packed {
      logic clear_wr;
      logic load;
      logic rd_en;
      logic exec;
      logic rsp_load;
   } cmd_type;

   // datapath to controller
   typedef struct packed {
      logic clear_last;
      logic hash_done;
      logic slot_free;
   } sts_type;

endpackage

`default_nettype wire

// ===== rtl/core/hashed_key_value_store_unit.sv =====
// Top level of the hashed key-value store: joins controller and datapath.
// Depends on hkvs_pkg, hkvs_ctrl, hkvs_dp and hkvs_mod.
`default_nettype none

// A key-value table of BUCKETS buckets with WAYS entries each. Every
// transaction carries an opcode (insert-or-update, lookup, remove), a signed
// key and a value, and yields exactly one result with a status and a read
// value. The bucket is the key magnitude modulo BUCKETS. After reset the block
// runs a clear pass over the bucket rows and stalls requests meanwhile. A
// transaction then passes, from one acceptance to the next, through the idle
// state in which it is accepted, the residue unit, which folds 8 key bits per
// cycle, a bucket row read, a compare-and-write-back step and a hand-off into
// the output register. The output register holds a result while the consumer
// stalls, so the block takes the next request meanwhile and waits in the
// hand-off only when a second result is ready before the first is taken.
module hashed_key_value_store_unit #(
   parameter int BUCKETS = 16,
   parameter int WAYS    = 4
) (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              req_valid,
   output logic                   req_stall,
   input  wire hkvs_pkg::req_type req_data,
   output logic                   rsp_valid,
   input  wire logic              rsp_stall,
   output hkvs_pkg::rsp_type      rsp_data
);
   import hkvs_pkg::*;

   cmd_type cmd;
   sts_type sts;

   // sequence each transaction; command and status structs are the only link
   hkvs_ctrl u_ctrl (
      .clock    (clock),
      .reset    (reset),
      .req_valid(req_valid),
      .req_stall(req_stall),
      .sts      (sts),
      .cmd      (cmd)
   );

   // hold the table rows, the way compare and the output register
   hkvs_dp #(
      .BUCKETS(BUCKETS),
      .WAYS   (WAYS)
   ) u_dp (
      .clock    (clock),
      .reset    (reset),
      .req_data (req_data),
      .cmd      (cmd),
      .sts      (sts),
      .rsp_valid(rsp_valid),
      .rsp_stall(rsp_stall),
      .rsp_data (rsp_data)
   );

endmodule

`default_nettype wire

// ===== rtl/core/hkvs_mod.sv =====
// Bucket residue unit: magnitude of a signed key modulo BUCKETS.
// Folds MOD_BITS key bits per cycle with compare-subtract steps; uses hkvs_pkg.
`default_nettype none

module hkvs_mod #(
   parameter int BUCKETS = 16
) (
   input  wire logic                           clock,
   input  wire logic                           reset,
   input  wire logic                           start,
   input  wire logic [hkvs_pkg::KEY_W-1:0]     key,
   output logic                                done,
   output logic [((BUCKETS > 1) ? $clog2(BUCKETS) : 1)-1:0] bucket
);
   import hkvs_pkg::*;

   localparam int BIDX_W = (BUCKETS > 1) ? $clog2(BUCKETS) : 1;
   localparam int STEPS  = KEY_W / MOD_BITS;
   localparam int CNT_W  = (STEPS > 1) ? $clog2(STEPS) : 1;
   localparam logic [BIDX_W:0]  BUCK_W    = (BIDX_W+1)'(BUCKETS);
   localparam logic [CNT_W-1:0] LAST_STEP = CNT_W'(STEPS - 1);

   logic [KEY_W-1:0]  mag_ff, mag_in;
   logic [BIDX_W-1:0] rem_ff, rem_in;
   logic [CNT_W-1:0]  cnt_ff, cnt_in;
   logic              run_ff, run_in;
   logic              done_ff, done_in;
   logic [BIDX_W:0]   rem_tmp;

   always_comb begin
      rem_tmp = {1'b0, rem_ff};
      for (int i = 0; i < MOD_BITS; i++) begin
         rem_tmp = {rem_tmp[BIDX_W-1:0], mag_ff[KEY_W-1-i]};
         if (rem_tmp >= BUCK_W) begin
            rem_tmp = rem_tmp - BUCK_W;
         end
      end
   end

   always_comb begin
      mag_in  = mag_ff;
      rem_in  = rem_ff;
      cnt_in  = cnt_ff;
      run_in  = run_ff;
      done_in = done_ff;
      priority if (start) begin
         // most negative key wraps to 2^31, which is its magnitude
         mag_in  = key[KEY_W-1] ? (KEY_W'(0) - key) : key;
         rem_in  = '0;
         cnt_in  = '0;
         run_in  = 1'b1;
         done_in = 1'b0;
      end else if (run_ff) begin
         mag_in = mag_ff << MOD_BITS;
         rem_in = rem_tmp[BIDX_W-1:0];
         cnt_in = cnt_ff + CNT_W'(1);
         if (cnt_ff == LAST_STEP) begin
            run_in  = 1'b0;
            done_in = 1'b1;
         end
      end else begin
         // hold the residue until the next start
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         run_ff  <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         run_ff  <= run_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      mag_ff <= mag_in;
      rem_ff <= rem_in;
   end

   assign done   = done_ff;
   assign bucket = rem_ff;

endmodule

`default_nettype wire

// ===== rtl/core/hkvs_ctrl.sv =====
// Controller of the hashed key-value store: sequences clear pass, hash,
// row read, compare-and-write and result hand-off. Uses hkvs_pkg.
`default_nettype none

module hkvs_ctrl (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              req_valid,
   output logic                   req_stall,
   input  wire hkvs_pkg::sts_type sts,
   output hkvs_pkg::cmd_type      cmd
);
   import hkvs_pkg::*;

   ctrl_state_type state_ff, state_in;

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         S_CLEAR: if (sts.clear_last) state_in = S_IDLE;
         S_IDLE:  if (req_valid) state_in = S_HASH;
         S_HASH:  if (sts.hash_done) state_in = S_EXEC;
         S_EXEC:  state_in = S_POST;
         S_POST:  if (sts.slot_free) state_in = S_IDLE;
         default: state_in = S_CLEAR;
      endcase
   end

   always_comb begin
      cmd       = '0;
      req_stall = 1'b1;
      unique case (state_ff)
         S_CLEAR: cmd.clear_wr = 1'b1;
         S_IDLE: begin
            req_stall = 1'b0;
            cmd.load  = req_valid;
         end
         S_HASH:  cmd.rd_en    = sts.hash_done;
         S_EXEC:  cmd.exec     = 1'b1;
         S_POST:  cmd.rsp_load = sts.slot_free;
         default: cmd = '0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_CLEAR;
      end else begin
         state_ff <= state_in;
      end
   end

   a_accept_to_hash: assert property (@(posedge clock) disable iff (reset)
      (req_valid && !req_stall) |=> (state_ff == S_HASH))
      else $error("accepted transaction did not start hashing");

   a_exec_once: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_EXEC) |=> (state_ff == S_POST))
      else $error("row write-back not followed by result hand-off");

   a_clear_holds: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_CLEAR && !sts.clear_last) |=> (state_ff == S_CLEAR))
      else $error("clear pass left early");

endmodule

`default_nettype wire

// ===== rtl/core/hkvs_dp.sv =====
// Datapath of the hashed key-value store: request register, residue unit,
// bucket row memories, way compare, result and output registers. Uses hkvs_pkg.
`default_nettype none

module hkvs_dp #(
   parameter int BUCKETS = 16,
   parameter int WAYS    = 4
) (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire hkvs_pkg::req_type req_data,
   input  wire hkvs_pkg::cmd_type cmd,
   output hkvs_pkg::sts_type      sts,
   output logic                   rsp_valid,
   input  wire logic              rsp_stall,
   output hkvs_pkg::rsp_type      rsp_data
);
   import hkvs_pkg::*;

   localparam int BIDX_W = (BUCKETS > 1) ? $clog2(BUCKETS) : 1;
   localparam logic [BIDX_W-1:0] LAST_ROW = BIDX_W'(BUCKETS - 1);

   // one row per bucket, all ways side by side
   logic [WAYS-1:0]             valid_mem [BUCKETS];
   logic [WAYS-1:0][KEY_W-1:0]  key_mem   [BUCKETS];
   logic [WAYS-1:0][VAL_W-1:0]  val_mem   [BUCKETS];

   req_type                     req_ff;
   logic [BIDX_W-1:0]           bucket;
   logic                        hash_done;
   logic [BIDX_W-1:0]           clr_idx_ff;
   logic [WAYS-1:0]             rd_valid_ff;
   logic [WAYS-1:0][KEY_W-1:0]  rd_key_ff;
   logic [WAYS-1:0][VAL_W-1:0]  rd_val_ff;
   logic [WAYS-1:0]             wr_valid;
   logic [WAYS-1:0][KEY_W-1:0]  wr_key;
   logic [WAYS-1:0][VAL_W-1:0]  wr_val;
   logic [WAYS-1:0]             hit_vec, hit_oh, free_vec, free_oh;
   logic [VAL_W-1:0]            hit_val;
   rsp_type                     res_in, res_ff, rsp_ff;
   logic                        rsp_valid_ff, rsp_valid_in;

   hkvs_mod #(
      .BUCKETS(BUCKETS)
   ) u_mod (
      .clock (clock),
      .reset (reset),
      .start (cmd.load),
      .key   (req_data.key),
      .done  (hash_done),
      .bucket(bucket)
   );

   always_ff @(posedge clock) begin
      if (cmd.load) begin
         req_ff <= req_data;
      end
   end

   // walk the rows once after reset to drop every valid mark
   always_ff @(posedge clock) begin
      if (reset) begin
         clr_idx_ff <= '0;
      end else if (cmd.clear_wr) begin
         clr_idx_ff <= clr_idx_ff + BIDX_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.rd_en) begin
         rd_valid_ff <= valid_mem[bucket];
         rd_key_ff   <= key_mem[bucket];
         rd_val_ff   <= val_mem[bucket];
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.clear_wr) begin
         valid_mem[clr_idx_ff] <= '0;
      end else if (cmd.exec) begin
         valid_mem[bucket] <= wr_valid;
         key_mem[bucket]   <= wr_key;
         val_mem[bucket]   <= wr_val;
      end
   end

   always_comb begin
      for (int w = 0; w < WAYS; w++) begin
         hit_vec[w] = rd_valid_ff[w] && (rd_key_ff[w] == req_ff.key);
      end
      free_vec = ~rd_valid_ff;
      // lowest set way only
      hit_oh  = hit_vec & (~hit_vec + WAYS'(1));
      free_oh = free_vec & (~free_vec + WAYS'(1));
      hit_val = '0;
      for (int w = 0; w < WAYS; w++) begin
         if (hit_oh[w]) begin
            hit_val = hit_val | rd_val_ff[w];
         end
      end
   end

   always_comb begin
      wr_valid = rd_valid_ff;
      wr_key   = rd_key_ff;
      wr_val   = rd_val_ff;
      res_in.status     = STAT_OK;
      res_in.read_value = '0;
      unique case (req_ff.opcode)
         OP_INSERT: begin
            priority if (|hit_vec) begin
               for (int w = 0; w < WAYS; w++) begin
                  if (hit_oh[w]) wr_val[w] = req_ff.new_value;
               end
            end else if (|free_vec) begin
               for (int w = 0; w < WAYS; w++) begin
                  if (free_oh[w]) begin
                     wr_valid[w] = 1'b1;
                     wr_key[w]   = req_ff.key;
                     wr_val[w]   = req_ff.new_value;
                  end
               end
            end else begin
               res_in.status = STAT_FULL;
            end
         end
         OP_LOOKUP: begin
            if (|hit_vec) begin
               res_in.read_value = hit_val;
            end else begin
               res_in.status     = STAT_NOT_FOUND;
               res_in.read_value = ABSENT_VALUE;
            end
         end
         OP_REMOVE: begin
            if (|hit_vec) begin
               wr_valid = rd_valid_ff & ~hit_oh;
            end else begin
               res_in.status = STAT_NOT_FOUND;
            end
         end
         default: res_in.status = STAT_OK;
      endcase
   end

   always_ff @(posedge clock) begin
      if (cmd.exec) begin
         res_ff <= res_in;
      end
      if (cmd.rsp_load) begin
         rsp_ff <= res_ff;
      end
   end

   always_comb begin
      priority if (cmd.rsp_load) begin
         rsp_valid_in = 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_in = 1'b0;
      end else begin
         // hold the waiting result
         rsp_valid_in = rsp_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign sts.clear_last = (clr_idx_ff == LAST_ROW);
   assign sts.hash_done  = hash_done;
   assign sts.slot_free  = !rsp_valid_ff || !rsp_stall;
   assign rsp_valid      = rsp_valid_ff;
   assign rsp_data       = rsp_ff;

endmodule

`default_nettype wire

// ===== tb/hashed_key_value_store_unit_tb.sv =====
// Self-checking testbench for the hashed key-value store unit.
// Depends on hkvs_pkg and hashed_key_value_store_unit; keeps its own copy of the
// bucket table to predict every result.

module hashed_key_value_store_unit_tb;
   timeunit 1ns;
   timeprecision 1ps;

   import hkvs_pkg::*;

   localparam int BUCKETS        = 16;
   localparam int WAYS           = 4;
   localparam int SLOTS          = BUCKETS * WAYS;
   localparam int WATCHDOG_LIMIT = 2000;
   localparam int DRAIN_CYCLES   = 16;

   // the fourth opcode encoding does nothing and answers status ok, value zero
   localparam logic [OP_W-1:0] OP_UNUSED = 2'd3;

   logic    clock     = 1'b0;
   logic    reset     = 1'b1;
   logic    req_valid = 1'b0;
   logic    req_stall;
   req_type req_data  = '0;
   logic    rsp_valid;
   logic    rsp_stall = 1'b0;
   rsp_type rsp_data;

   // shadow of the bucket table; a slot's key and value are only read while live
   logic [KEY_W-1:0] table_key   [SLOTS];
   logic [VAL_W-1:0] table_value [SLOTS];
   logic             table_live  [SLOTS];

   rsp_type          pending_results[$];
   logic [KEY_W-1:0] known_keys[$];

   bit idle_enable = 1'b1;
   int failures        = 0;
   int results_checked = 0;
   int quiet_cycles    = 0;
   int stall_left      = 0;
   int op_count[4]     = '{default: 0};
   int status_count[4] = '{default: 0};

   hashed_key_value_store_unit #(
      .BUCKETS (BUCKETS),
      .WAYS    (WAYS)
   ) dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // Apply one transaction to the shadow table and return the result it earns.
   // The bucket is the key magnitude, as an unsigned 32-bit number, mod BUCKETS;
   // the most negative key therefore lands in bucket zero.
   function automatic rsp_type apply_to_table(input req_type item);
      logic [KEY_W-1:0] key_bits;
      logic [KEY_W-1:0] magnitude;
      int               base;
      int               hit_way;
      rsp_type          outcome;
      key_bits           = item.key;
      magnitude          = key_bits[KEY_W-1] ? (32'd0 - key_bits) : key_bits;
      base               = int'(magnitude % BUCKETS) * WAYS;
      hit_way            = -1;
      outcome.status     = STAT_OK;
      outcome.read_value = '0;
      for (int w = 0; w < WAYS; w++) begin
         if (table_live[base + w] && table_key[base + w] == key_bits) begin
            hit_way = w;
            break;
         end
      end
      case (item.opcode)
         OP_INSERT: begin
            if (hit_way >= 0) begin
               table_value[base + hit_way] = item.new_value;
            end else begin
               // take the lowest free way, or report the bucket as full
               outcome.status = STAT_FULL;
               for (int w = 0; w < WAYS; w++) begin
                  if (!table_live[base + w]) begin
                     table_live[base + w]  = 1'b1;
                     table_key[base + w]   = key_bits;
                     table_value[base + w] = item.new_value;
                     outcome.status        = STAT_OK;
                     break;
                  end
               end
            end
         end
         OP_LOOKUP: begin
            if (hit_way >= 0) begin
               outcome.read_value = table_value[base + hit_way];
            end else begin
               outcome.status     = STAT_NOT_FOUND;
               outcome.read_value = ABSENT_VALUE;
            end
         end
         OP_REMOVE: begin
            if (hit_way >= 0) begin
               table_live[base + hit_way] = 1'b0;
            end else begin
               outcome.status = STAT_NOT_FOUND;
            end
         end
         default: begin
         end
      endcase
      return outcome;
   endfunction

   // Drive one transaction and hold it until accepted. Valid is left high on
   // return so that a back-to-back transaction never lowers and raises it in
   // the same step; an idle gap or the end of the run lowers it.
   task automatic send_request(input logic [OP_W-1:0] opcode, input logic [KEY_W-1:0] key,
                               input logic [VAL_W-1:0] value);
      req_type item;
      rsp_type predicted;
      int      gap;
      item.opcode    = opcode;
      item.key       = key;
      item.new_value = value;
      if (idle_enable && $urandom_range(0, 3) == 0) begin
         gap = $urandom_range(1, 13);
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_data  <= item;
      do @(posedge clock); while (req_stall);
      predicted       = apply_to_table(item);
      pending_results = {pending_results, predicted};
      op_count[opcode]++;
   endtask

   // Empty table misses, then insert, update, lookup and remove of one key.
   task automatic test_basic_operations();
      send_request(OP_LOOKUP, 32'd5, 32'd0);
      send_request(OP_REMOVE, 32'd5, 32'd0);
      send_request(OP_INSERT, 32'd5, 32'd100);
      send_request(OP_LOOKUP, 32'd5, 32'd0);
      send_request(OP_INSERT, 32'd5, -32'sd7);
      send_request(OP_LOOKUP, 32'd5, 32'hDEAD_BEEF);
      send_request(OP_REMOVE, 32'd5, 32'd0);
      send_request(OP_LOOKUP, 32'd5, 32'd0);
   endtask

   // Fill bucket 3 with keys of either sign, overflow it, free one way and refill.
   task automatic test_bucket_overflow();
      send_request(OP_INSERT, 32'd3,    32'd30);
      send_request(OP_INSERT, -32'sd3,  32'd31);
      send_request(OP_INSERT, 32'd19,   32'd32);
      send_request(OP_INSERT, -32'sd19, 32'd33);
      send_request(OP_INSERT, 32'd35,   32'd34);
      send_request(OP_REMOVE, -32'sd3,  32'd0);
      send_request(OP_INSERT, 32'd35,   32'd35);
      send_request(OP_LOOKUP, 32'd35,   32'd0);
      send_request(OP_LOOKUP, 32'd19,   32'd0);
   endtask

   // Most negative, most positive and zero keys, plus the unused opcode.
   task automatic test_key_extremes();
      send_request(OP_INSERT, 32'h8000_0000, 32'h7FFF_FFFF);
      send_request(OP_INSERT, 32'h7FFF_FFFF, 32'h8000_0000);
      send_request(OP_INSERT, 32'd0,         32'hFFFF_FFFF);
      send_request(OP_LOOKUP, 32'h8000_0000, 32'd0);
      send_request(OP_LOOKUP, 32'h7FFF_FFFF, 32'd0);
      send_request(OP_UNUSED, 32'd0,         32'h1234_5678);
      send_request(OP_LOOKUP, 32'd0,         32'd0);
   endtask

   // Random traffic, mostly on a handful of crowded buckets and on keys already
   // seen, so that hits, updates, removals and full buckets all occur often.
   task automatic test_random_traffic(input int count, input bit allow_idle);
      logic [OP_W-1:0]  opcode;
      logic [KEY_W-1:0] key;
      logic [KEY_W-1:0] magnitude;
      int               roll;
      for (int n = 0; n < count; n++) begin
         if (n % 40 == 0) idle_enable = allow_idle && ($urandom_range(0, 3) != 0);
         roll = $urandom_range(0, 99);
         if (roll < 42)      opcode = OP_INSERT;
         else if (roll < 72) opcode = OP_LOOKUP;
         else if (roll < 95) opcode = OP_REMOVE;
         else                opcode = OP_UNUSED;
         roll = $urandom_range(0, 99);
         if (roll < 45 && known_keys.size() > 0) begin
            key = known_keys[$urandom_range(0, known_keys.size() - 1)];
         end else if (roll < 85) begin
            magnitude = $urandom_range(0, 5) + BUCKETS * $urandom_range(0, 7);
            key = $urandom_range(0, 1) ? (32'd0 - magnitude) : magnitude;
         end else begin
            key = $urandom();
         end
         if (opcode == OP_INSERT) begin
            known_keys = {known_keys, key};
            if (known_keys.size() > 64) void'(known_keys.pop_front());
         end
         send_request(opcode, key, $urandom());
      end
   endtask

   // Check each accepted result against the oldest prediction, and drive the
   // result-side stall in random bursts.
   always @(posedge clock) begin : result_check
      rsp_type want;
      if (reset) begin
         rsp_stall <= 1'b0;
         stall_left = 0;
      end else begin
         if (rsp_valid && !rsp_stall) begin
            results_checked++;
            status_count[rsp_data.status]++;
            if (pending_results.size() == 0) begin
               $error("result with no transaction pending: status %0d, read_value %0d",
                      rsp_data.status, rsp_data.read_value);
               failures++;
            end else begin
               want = pending_results.pop_front();
               if (rsp_data.status !== want.status) begin
                  $error("status mismatch: expected %0d, actual %0d",
                         want.status, rsp_data.status);
                  failures++;
               end
               if (rsp_data.read_value !== want.read_value) begin
                  $error("read_value mismatch: expected %0d, actual %0d",
                         want.read_value, rsp_data.read_value);
                  failures++;
               end
            end
         end
         if (!idle_enable) stall_left = 0;
         else if (stall_left > 0) stall_left--;
         else if ($urandom_range(0, 4) == 0) stall_left = $urandom_range(1, 13);
         rsp_stall <= (stall_left > 0);
      end
   end

   // Abort if neither channel moves a transaction for too long.
   always @(posedge clock) begin
      if (reset || (req_valid && !req_stall) || (rsp_valid && !rsp_stall)) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
         $display("hashed_key_value_store_unit test failed");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   initial begin
      for (int s = 0; s < SLOTS; s++) table_live[s] = 1'b0;
      repeat (5) @(posedge clock);
      reset <= 1'b0;

      test_basic_operations();
      test_bucket_overflow();
      test_key_extremes();
      test_random_traffic(440, 1'b1);
      // finish with a stretch of full-rate traffic on both sides
      test_random_traffic(60, 1'b0);

      req_valid <= 1'b0;
      while (pending_results.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);

      $display("Covered %0d inserts, %0d lookups, %0d removes and %0d unused-opcode requests.",
               op_count[OP_INSERT], op_count[OP_LOOKUP], op_count[OP_REMOVE],
               op_count[OP_UNUSED]);
      $display("Checked %0d results: %0d ok, %0d not found, %0d bucket full; %0d failures.",
               results_checked, status_count[STAT_OK], status_count[STAT_NOT_FOUND],
               status_count[STAT_FULL], failures);
      if (failures == 0) begin
         $display("hashed_key_value_store_unit test passed");
      end else begin
         $display("hashed_key_value_store_unit test failed");
      end
      $finish;
   end

endmodule
